// ===== rtl/rau_pkg.sv =====
// package for the rational arithmetic unit: widths, codes, state type
package rau_pkg;
    localparam int WORD_BITS = 32;
    localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

    typedef logic [2:0] t_action;
    localparam t_action ACT_ADD = 3'd0;
    localparam t_action ACT_SUB = 3'd1;
    localparam t_action ACT_MUL = 3'd2;
    localparam t_action ACT_DIV = 3'd3;
    localparam t_action ACT_SIMP = 3'd4;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_OVF  = 2'd1;
    localparam t_status ST_ZERO = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_MUL3, S_SUM,
        S_GCD_CHK, S_GCD_DIV, S_QN_DIV, S_QD_DIV, S_DIV_RUN, S_DONE
    } t_state;

    // low WORD_BITS of a field as a signed working word
    function automatic logic signed [WORD_BITS-1:0] sx(input logic [31:0] v);
        begin
            sx = v[WORD_BITS-1:0];
        end
    endfunction
endpackage

// ===== rtl/rational_arithmetic_unit.sv =====
// top level of the rational arithmetic unit with iterative gcd reduction
//
//  channel | signals                                       | dir
//  --------+-----------------------------------------------+-----
//  input   | i_valid/o_ready, i_action, i_a_num .. i_b_den  | in
//  result  | o_valid/i_ready, o_res_num, o_res_den, o_status| out
//
// add/sub step through MUL1, MUL2, MUL3 and SUM, mul/div through MUL1 and MUL2, one multiplier shared over the products
// simplify runs euclid on one shift-subtract divider, one divider run per
// remainder step, followed by two quotient divisions by the gcd
// reset clears control only; payload registers are written before use
// one item in flight; o_ready is low while busy or while the result waits
module rational_arithmetic_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic signed [31:0] i_a_num,
    input  logic signed [31:0] i_a_den,
    input  logic signed [31:0] i_b_num,
    input  logic signed [31:0] i_b_den,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_res_num,
    output logic signed [31:0] o_res_den,
    output logic [1:0]  o_status
);
    import rau_pkg::*;
    localparam int W = WORD_BITS;

    t_state r_state, n_state, r_ret, n_ret;
    t_action r_act;
    logic signed [W-1:0] r_an, r_ad, r_bn, r_bd;
    logic signed [W-1:0] r_p1, r_rn, r_rd, r_ga, r_gb;
    logic r_ovf;
    // divider: magnitude restoring division
    logic [W-1:0] r_dq, r_dd;      // quotient/dividend shift reg, divisor mag
    logic [W:0]   r_drem;
    logic [CNT_BITS-1:0] r_cnt;
    logic r_qneg, r_rneg;
    logic signed [W-1:0] r_dn_s, r_dd_s;  // signed operands of current division

    // shared multiplier
    logic signed [W-1:0] m_a, m_b;
    logic signed [2*W-1:0] m_p;
    logic m_ovf;
    always_comb begin
        m_a = r_an; m_b = r_bd;
        case (r_state)
            S_MUL1: begin m_a = r_an; m_b = (r_act == ACT_MUL) ? r_bn : r_bd; end
            S_MUL2: begin m_a = r_ad; m_b = (r_act == ACT_DIV) ? r_bn : r_bd; end
            S_MUL3: begin m_a = r_bn; m_b = r_ad; end
            default: ;
        endcase
        m_p = m_a * m_b;
        m_ovf = (m_p != {{W{m_p[W-1]}}, m_p[W-1:0]});
    end

    // add/sub of the cross products
    logic signed [W:0] s_sum;
    always_comb begin
        if (r_act == ACT_ADD) s_sum = {r_p1[W-1], r_p1} + {r_rn[W-1], r_rn};
        else s_sum = {r_p1[W-1], r_p1} - {r_rn[W-1], r_rn};
    end

    // divider step
    logic [W:0] d_shift, d_sub;
    logic [W-1:0] q_mag, rem_mag;
    logic signed [W-1:0] q_s, rem_s;
    always_comb begin
        d_shift = {r_drem[W-1:0], r_dq[W-1]};
        d_sub = d_shift - {1'b0, r_dd};
        q_mag = r_dq;
        rem_mag = r_drem[W-1:0];
        q_s = r_qneg ? -q_mag : q_mag;
        rem_s = r_rneg ? -rem_mag : rem_mag;
    end
    logic [W-1:0] dn_mag, dd_mag;
    assign dn_mag = r_dn_s[W-1] ? -r_dn_s : r_dn_s;
    assign dd_mag = r_dd_s[W-1] ? -r_dd_s : r_dd_s;

    // quotient wraps only for most negative by minus one
    logic q_ovf;
    assign q_ovf = r_qneg == 1'b0 && q_mag[W-1];

    always_comb begin
        n_state = r_state;
        n_ret = r_ret;
        case (r_state)
            S_IDLE: if (i_valid) begin
                case (i_action)
                    ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: n_state = S_MUL1;
                    ACT_SIMP: n_state = S_GCD_CHK;
                    default: n_state = S_DONE;
                endcase
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = (r_act == ACT_ADD || r_act == ACT_SUB) ? S_MUL3 : S_DONE;
            S_MUL3: n_state = S_SUM;
            S_SUM: n_state = S_DONE;
            S_GCD_CHK: begin
                if (r_gb != '0) begin n_state = S_DIV_RUN; n_ret = S_GCD_DIV; end
                else if (r_ga == '0) n_state = S_DONE;
                else begin n_state = S_DIV_RUN; n_ret = S_QN_DIV; end
            end
            S_DIV_RUN: if (r_cnt == CNT_BITS'(W)) n_state = r_ret;
            S_GCD_DIV: n_state = S_GCD_CHK;
            S_QN_DIV: begin n_state = S_DIV_RUN; n_ret = S_QD_DIV; end
            S_QD_DIV: n_state = S_DONE;
            S_DONE: if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == S_IDLE);
        o_valid = (r_state == S_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret <= n_ret;
        end
    end

    // clear the divider count when entering a division; operands load on its first step
    logic start_div;
    assign start_div = n_state == S_DIV_RUN && r_state != S_DIV_RUN;

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_act <= i_action;
                r_an <= sx(i_a_num);
                r_ad <= sx(i_a_den);
                r_bn <= sx(i_b_num);
                r_bd <= sx(i_b_den);
                r_rn <= sx(i_a_num);
                r_rd <= sx(i_a_den);
                r_ga <= sx(i_a_num);
                r_gb <= sx(i_a_den);
                r_ovf <= 1'b0;
            end
            S_MUL1: begin
                r_p1 <= m_p[W-1:0];
                r_rn <= m_p[W-1:0];
                r_ovf <= r_ovf | m_ovf;
            end
            S_MUL2: begin r_rd <= m_p[W-1:0]; r_ovf <= r_ovf | m_ovf; end
            S_MUL3: begin r_rn <= m_p[W-1:0]; r_ovf <= r_ovf | m_ovf; end
            S_SUM: begin
                r_rn <= s_sum[W-1:0];
                r_ovf <= r_ovf | (s_sum[W] != s_sum[W-1]);
            end
            S_GCD_DIV: begin r_ga <= r_gb; r_gb <= rem_s; end
            S_QN_DIV: begin r_rn <= q_s; r_ovf <= r_ovf | q_ovf; end
            S_QD_DIV: begin r_rd <= q_s; r_ovf <= r_ovf | q_ovf; end
            default: ;
        endcase
        // division operand select
        if (r_state == S_GCD_CHK) begin
            r_dn_s <= (r_gb != '0) ? r_ga : r_an;
            r_dd_s <= (r_gb != '0) ? r_gb : r_ga;
        end else if (r_state == S_QN_DIV) begin
            r_dn_s <= r_ad;
        end
        if (r_state == S_DIV_RUN && r_cnt == '0) begin
            r_dq <= dn_mag;
            r_dd <= dd_mag;
            r_drem <= '0;
            r_qneg <= r_dn_s[W-1] ^ r_dd_s[W-1];
            r_rneg <= r_dn_s[W-1];
            r_cnt <= r_cnt + 1'b1;
        end else if (r_state == S_DIV_RUN) begin
            if (!d_sub[W]) begin
                r_drem <= d_sub;
                r_dq <= {r_dq[W-2:0], 1'b1};
            end else begin
                r_drem <= d_shift;
                r_dq <= {r_dq[W-2:0], 1'b0};
            end
            r_cnt <= (r_cnt == CNT_BITS'(W)) ? '0 : r_cnt + 1'b1;
        end else if (start_div || r_state == S_IDLE) begin
            r_cnt <= '0;
        end
    end

    // outputs, sign extended from the working width
    logic signed [W-1:0] fin_n, fin_d;
    assign fin_n = r_rn;
    assign fin_d = r_rd;
    assign o_res_num = 32'(fin_n);
    assign o_res_den = 32'(fin_d);
    always_comb begin
        if (r_act == ACT_SIMP && r_ga == '0 && r_gb == '0) o_status = ST_ZERO;
        else if (r_ovf) o_status = ST_OVF;
        else o_status = ST_OK;
    end

    // checks
    a_no_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready)) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_res_num) && $stable(o_status))
        else $error("result changed while stalled");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV_RUN |-> r_cnt <= CNT_BITS'(W))
        else $error("divider count overrun");
endmodule
